// ===== sv/txt_tok_pkg.sv =====
// ============================================================================
// txt_tok_pkg: shared types and constants for the text tokenizer
// Character codes, scan modes, token kinds and the result beat layout.
// ============================================================================
package txt_tok_pkg;

    // Widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;
    localparam int KIND_W = 2;

    // Default maximum token length in bytes
    localparam int MAX_TOKEN_LEN_DEF = 1499;

    // Configuration register map (byte addresses are 4 * index)
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int REG_QUOTE_CHAR = 0;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_EOD         = 8'h00;
    localparam logic [BYTE_W-1:0] CH_NEWLINE     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE       = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SLASH       = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_LBRACE      = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE      = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LPAREN      = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN      = 8'h29;
    localparam logic [BYTE_W-1:0] CH_APOSTROPHE  = 8'h27;
    localparam logic [BYTE_W-1:0] CH_COMMA       = 8'h2C;
    localparam logic [BYTE_W-1:0] QUOTE_CHAR_RST = 8'h22;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_WORD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUOTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PUNCT  = 2'd2;

    // Scan modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_SLASH   = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_WORD    = 5'b01000,
        MODE_QUOTE   = 5'b10000
    } scan_mode_t;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] tok_byte;
        logic              tok_last;
        logic              tok_empty;
        logic [KIND_W-1:0] tok_kind;
    } tok_beat_t;

    // Single-character tokens
    function automatic logic is_punct(input logic [BYTE_W-1:0] b);
        return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
               (b == CH_RPAREN) || (b == CH_APOSTROPHE) || (b == CH_COMMA);
    endfunction

endpackage

// ===== sv/text_tokenizer_stream.sv =====
// ============================================================================
// text_tokenizer_stream: byte-serial text tokenizer
// Splits a byte stream into words, quoted strings and punctuation tokens,
// one token byte per result beat, with comment and whitespace skipping.
// ============================================================================
// Throughput: one text byte accepted per cycle while the result queue has room;
// one result beat leaves per cycle while m_ready is high. Each result is queued
// when the byte that completes it is accepted; a word byte is held back until
// the following byte decides its last flag. A byte yields at most two beats; a
// four-entry result queue takes input while it has room for two.
// Reset (aresetn low, synchronous): queue emptied, scan idle, quote_char = 34.
module text_tokenizer_stream #(
    parameter int MAX_TOKEN_LEN = txt_tok_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [txt_tok_pkg::PADDR_W-1:0]    paddr,
    input  logic [txt_tok_pkg::PDATA_W-1:0]    pwdata,
    output logic [txt_tok_pkg::PDATA_W-1:0]    prdata,
    output logic                               pready,
    // Text input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [txt_tok_pkg::BYTE_W-1:0]     s_ch,
    // Token output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [txt_tok_pkg::BYTE_W-1:0]     m_tok_byte,
    output logic                               m_tok_last,
    output logic                               m_tok_empty,
    output logic [txt_tok_pkg::KIND_W-1:0]     m_tok_kind
);

    localparam int LEN_W = txt_tok_pkg::LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);

    // Configuration and scan state
    logic [txt_tok_pkg::BYTE_W-1:0] quote_reg;
    txt_tok_pkg::scan_mode_t        mode_reg, mode_next;
    logic [txt_tok_pkg::BYTE_W-1:0] held_reg, held_next;
    logic                           hv_reg, hv_next;
    logic [LEN_W-1:0]               len_reg, len_next;

    // Result queue
    txt_tok_pkg::tok_beat_t q_mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;

    // Beats produced by the current byte
    logic                   a_valid, b_valid;
    txt_tok_pkg::tok_beat_t a_beat, b_beat;

    logic s_fire, m_fire, cfg_wr;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // APB: always ready, quote register at index 0
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[txt_tok_pkg::PADDR_W-1:2] == 1'(txt_tok_pkg::REG_QUOTE_CHAR)) begin
            prdata = {{(txt_tok_pkg::PDATA_W-txt_tok_pkg::BYTE_W){1'b0}}, quote_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_reg <= txt_tok_pkg::QUOTE_CHAR_RST;
        end else if (cfg_wr &&
                     paddr[txt_tok_pkg::PADDR_W-1:2] ==
                     1'(txt_tok_pkg::REG_QUOTE_CHAR)) begin
            quote_reg <= pwdata[txt_tok_pkg::BYTE_W-1:0];
        end
    end

    // Scan decision for one byte
    always_comb begin
        logic                           is_ws;
        logic                           is_pu;
        txt_tok_pkg::scan_mode_t        eff_mode;
        logic [txt_tok_pkg::BYTE_W-1:0] eff_held;
        logic                           eff_hv;
        logic [LEN_W-1:0]               eff_len;
        logic [LEN_W-1:0]               len_inc;
        txt_tok_pkg::scan_mode_t        idl_mode;
        logic [txt_tok_pkg::BYTE_W-1:0] idl_held;
        logic                           idl_hv;
        logic [LEN_W-1:0]               idl_len;
        logic                           idl_punct;
        logic                           grow_en;
        logic [txt_tok_pkg::KIND_W-1:0] grow_kind;

        is_ws = (s_ch <= txt_tok_pkg::CH_SPACE);
        is_pu = txt_tok_pkg::is_punct(s_ch);

        // Fresh scan of the byte from idle
        idl_mode  = txt_tok_pkg::MODE_IDLE;
        idl_held  = '0;
        idl_hv    = 1'b0;
        idl_len   = '0;
        idl_punct = 1'b0;
        if (is_ws) begin
            idl_mode = txt_tok_pkg::MODE_IDLE;
        end else if (s_ch == txt_tok_pkg::CH_SLASH) begin
            idl_mode = txt_tok_pkg::MODE_SLASH;
        end else if (s_ch == quote_reg) begin
            idl_mode = txt_tok_pkg::MODE_QUOTE;
        end else if (is_pu) begin
            idl_punct = 1'b1;
        end else begin
            idl_mode = txt_tok_pkg::MODE_WORD;
            idl_held = s_ch;
            idl_hv   = 1'b1;
            idl_len  = LEN_W'(1);
        end

        // Resolve a pending lone slash into the token it opens
        eff_mode = mode_reg;
        eff_held = held_reg;
        eff_hv   = hv_reg;
        eff_len  = len_reg;
        if (mode_reg == txt_tok_pkg::MODE_SLASH && s_ch != txt_tok_pkg::CH_SLASH) begin
            if (quote_reg == txt_tok_pkg::CH_SLASH) begin
                eff_mode = txt_tok_pkg::MODE_QUOTE;
                eff_hv   = 1'b0;
                eff_len  = '0;
            end else begin
                eff_mode = txt_tok_pkg::MODE_WORD;
                eff_held = txt_tok_pkg::CH_SLASH;
                eff_hv   = 1'b1;
                eff_len  = LEN_W'(1);
            end
        end
        len_inc = eff_len + LEN_W'(1);

        mode_next = mode_reg;
        held_next = held_reg;
        hv_next   = hv_reg;
        len_next  = len_reg;
        a_valid   = 1'b0;
        b_valid   = 1'b0;
        a_beat    = '0;
        b_beat    = '0;
        grow_en   = 1'b0;
        grow_kind = txt_tok_pkg::KIND_WORD;

        case (eff_mode)
            txt_tok_pkg::MODE_SLASH: begin
                // Second slash: comment to end of line
                mode_next = txt_tok_pkg::MODE_COMMENT;
            end
            txt_tok_pkg::MODE_COMMENT: begin
                if (s_ch == txt_tok_pkg::CH_NEWLINE || s_ch == txt_tok_pkg::CH_EOD) begin
                    mode_next = txt_tok_pkg::MODE_IDLE;
                    held_next = '0;
                    hv_next   = 1'b0;
                    len_next  = '0;
                end
            end
            txt_tok_pkg::MODE_WORD: begin
                if (is_ws || is_pu) begin
                    // Close the word, then scan the byte fresh
                    a_valid   = 1'b1;
                    a_beat    = '{tok_byte: eff_held, tok_last: 1'b1, tok_empty: 1'b0,
                                  tok_kind: txt_tok_pkg::KIND_WORD};
                    mode_next = idl_mode;
                    held_next = idl_held;
                    hv_next   = idl_hv;
                    len_next  = idl_len;
                    b_valid   = idl_punct;
                    b_beat    = '{tok_byte: s_ch, tok_last: 1'b1, tok_empty: 1'b0,
                                  tok_kind: txt_tok_pkg::KIND_PUNCT};
                end else begin
                    grow_en   = 1'b1;
                    grow_kind = txt_tok_pkg::KIND_WORD;
                end
            end
            txt_tok_pkg::MODE_QUOTE: begin
                if (s_ch == quote_reg || s_ch == txt_tok_pkg::CH_EOD) begin
                    // Close the quoted token, empty if nothing was taken
                    a_valid   = 1'b1;
                    a_beat    = '{tok_byte: eff_hv ? eff_held : '0, tok_last: 1'b1,
                                  tok_empty: !eff_hv, tok_kind: txt_tok_pkg::KIND_QUOTED};
                    mode_next = txt_tok_pkg::MODE_IDLE;
                    held_next = '0;
                    hv_next   = 1'b0;
                    len_next  = '0;
                end else begin
                    grow_en   = 1'b1;
                    grow_kind = txt_tok_pkg::KIND_QUOTED;
                end
            end
            default: begin
                mode_next = idl_mode;
                held_next = idl_held;
                hv_next   = idl_hv;
                len_next  = idl_len;
                b_valid   = idl_punct;
                b_beat    = '{tok_byte: s_ch, tok_last: 1'b1, tok_empty: 1'b0,
                              tok_kind: txt_tok_pkg::KIND_PUNCT};
            end
        endcase

        // Extend the open token: release the held byte, hold the new one
        if (grow_en) begin
            a_valid = eff_hv;
            a_beat  = '{tok_byte: eff_held, tok_last: 1'b0, tok_empty: 1'b0,
                        tok_kind: grow_kind};
            if (len_inc >= MAX_LEN) begin
                b_valid   = 1'b1;
                b_beat    = '{tok_byte: s_ch, tok_last: 1'b1, tok_empty: 1'b0,
                              tok_kind: grow_kind};
                mode_next = txt_tok_pkg::MODE_IDLE;
                held_next = '0;
                hv_next   = 1'b0;
                len_next  = '0;
            end else begin
                mode_next = eff_mode;
                held_next = s_ch;
                hv_next   = 1'b1;
                len_next  = len_inc;
            end
        end
    end

    // Advance scan state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= txt_tok_pkg::MODE_IDLE;
            held_reg <= '0;
            hv_reg   <= 1'b0;
            len_reg  <= '0;
        end else if (s_fire) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            hv_reg   <= hv_next;
            len_reg  <= len_next;
        end
    end

    // Result queue: push up to two beats, pop one
    assign s_ready = (count_reg <= 3'd2);
    assign m_valid = (count_reg != 3'd0);

    always_comb begin
        count_next = count_reg;
        if (s_fire) begin
            count_next = count_next + {2'b00, a_valid} + {2'b00, b_valid};
        end
        if (m_fire) begin
            count_next = count_next - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                wr_ptr_reg <= wr_ptr_reg + {1'b0, a_valid} + {1'b0, b_valid};
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

    // Hold the beat storage
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (a_valid) begin
                q_mem[wr_ptr_reg] <= a_beat;
            end
            if (b_valid) begin
                q_mem[wr_ptr_reg + {1'b0, a_valid}] <= b_beat;
            end
        end
    end

    assign m_tok_byte  = q_mem[rd_ptr_reg].tok_byte;
    assign m_tok_last  = q_mem[rd_ptr_reg].tok_last;
    assign m_tok_empty = q_mem[rd_ptr_reg].tok_empty;
    assign m_tok_kind  = q_mem[rd_ptr_reg].tok_kind;

endmodule

// ===== verif/tb_text_tokenizer_stream.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_text_tokenizer_stream: self-checking testbench for the text tokenizer
// Feeds text bytes with random gaps on both sides and predicts every token
// beat with a behavioural scanner. Each beat that leaves is compared with the
// oldest prediction. Covers quote settings, the length limit and output stalls.
// ============================================================================
module tb_text_tokenizer_stream;

    localparam int BYTE_W         = txt_tok_pkg::BYTE_W;
    localparam int LEN_W          = txt_tok_pkg::LEN_W;
    localparam int KIND_W         = txt_tok_pkg::KIND_W;
    localparam int PADDR_W        = txt_tok_pkg::PADDR_W;
    localparam int PDATA_W        = txt_tok_pkg::PDATA_W;
    localparam int MAX_LEN        = txt_tok_pkg::MAX_TOKEN_LEN_DEF;
    localparam int GAP_MAX        = 18;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 220;
    localparam int REPORT_MAX     = 10;
    localparam logic [PADDR_W-1:0] ADDR_QUOTE_CHAR =
        PADDR_W'(txt_tok_pkg::REG_QUOTE_CHAR * 4);

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_ch    = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [BYTE_W-1:0]   m_tok_byte;
    logic                m_tok_last;
    logic                m_tok_empty;
    logic [KIND_W-1:0]   m_tok_kind;

    // Scanner prediction state
    txt_tok_pkg::scan_mode_t scan_mode;
    logic [BYTE_W-1:0]       held_byte;
    logic                    held_valid;
    logic [LEN_W-1:0]        token_len;
    logic [BYTE_W-1:0]       quote_char;
    txt_tok_pkg::tok_beat_t  pending_beats[$];

    int   mismatch_count = 0;
    int   bytes_sent     = 0;
    int   tx_gap_max     = GAP_MAX;
    int   rx_gap_max     = GAP_MAX;
    logic rx_hold_req    = 1'b0;
    int   idle_cycles    = 0;

    always #2 aclk = ~aclk;

    text_tokenizer_stream #(
        .MAX_TOKEN_LEN (MAX_LEN)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tok_byte  (m_tok_byte),
        .m_tok_last  (m_tok_last),
        .m_tok_empty (m_tok_empty),
        .m_tok_kind  (m_tok_kind)
    );

    // ------------------------------------------------------------------------
    // Scanner prediction
    // ------------------------------------------------------------------------
    function automatic logic is_single(input logic [BYTE_W-1:0] b);
        return b == txt_tok_pkg::CH_LBRACE || b == txt_tok_pkg::CH_RBRACE ||
               b == txt_tok_pkg::CH_LPAREN || b == txt_tok_pkg::CH_RPAREN ||
               b == txt_tok_pkg::CH_APOSTROPHE || b == txt_tok_pkg::CH_COMMA;
    endfunction

    function automatic void push_beat(input logic [BYTE_W-1:0] b, input logic last,
                                      input logic empty, input logic [KIND_W-1:0] kind);
        txt_tok_pkg::tok_beat_t beat;
        beat.tok_byte  = b;
        beat.tok_last  = last;
        beat.tok_empty = empty;
        beat.tok_kind  = kind;
        pending_beats.push_back(beat);
    endfunction

    function automatic void return_to_idle();
        scan_mode  = txt_tok_pkg::MODE_IDLE;
        held_valid = 1'b0;
        held_byte  = '0;
        token_len  = '0;
    endfunction

    function automatic void open_quoted();
        scan_mode  = txt_tok_pkg::MODE_QUOTE;
        held_valid = 1'b0;
        token_len  = '0;
    endfunction

    // Decide a byte seen with no token open
    function automatic void start_from_idle(input logic [BYTE_W-1:0] b);
        if (b <= txt_tok_pkg::CH_SPACE) begin
            // whitespace and end of data: nothing opens
        end else if (b == txt_tok_pkg::CH_SLASH) begin
            scan_mode = txt_tok_pkg::MODE_SLASH;
        end else if (b == quote_char) begin
            open_quoted();
        end else if (is_single(b)) begin
            push_beat(b, 1'b1, 1'b0, txt_tok_pkg::KIND_PUNCT);
        end else begin
            scan_mode  = txt_tok_pkg::MODE_WORD;
            held_byte  = b;
            held_valid = 1'b1;
            token_len  = LEN_W'(1);
        end
    endfunction

    // Release the held byte and hold the new one; close at the length limit
    function automatic void extend_token(input logic [BYTE_W-1:0] b,
                                         input logic [KIND_W-1:0] kind);
        if (held_valid)
            push_beat(held_byte, 1'b0, 1'b0, kind);
        token_len = token_len + 1'b1;
        if (token_len >= MAX_LEN) begin
            push_beat(b, 1'b1, 1'b0, kind);
            return_to_idle();
        end else begin
            held_byte  = b;
            held_valid = 1'b1;
        end
    endfunction

    function automatic void word_byte(input logic [BYTE_W-1:0] b);
        if (b <= txt_tok_pkg::CH_SPACE || is_single(b)) begin
            push_beat(held_byte, 1'b1, 1'b0, txt_tok_pkg::KIND_WORD);
            return_to_idle();
            start_from_idle(b);
        end else begin
            extend_token(b, txt_tok_pkg::KIND_WORD);
        end
    endfunction

    function automatic void quoted_byte(input logic [BYTE_W-1:0] b);
        if (b == quote_char || b == txt_tok_pkg::CH_EOD) begin
            if (held_valid)
                push_beat(held_byte, 1'b1, 1'b0, txt_tok_pkg::KIND_QUOTED);
            else
                push_beat('0, 1'b1, 1'b1, txt_tok_pkg::KIND_QUOTED);
            return_to_idle();
        end else begin
            extend_token(b, txt_tok_pkg::KIND_QUOTED);
        end
    endfunction

    function automatic void scan_byte(input logic [BYTE_W-1:0] b);
        case (scan_mode)
            txt_tok_pkg::MODE_SLASH: begin
                if (b == txt_tok_pkg::CH_SLASH) begin
                    scan_mode = txt_tok_pkg::MODE_COMMENT;
                end else if (quote_char == txt_tok_pkg::CH_SLASH) begin
                    open_quoted();
                    quoted_byte(b);
                end else begin
                    scan_mode  = txt_tok_pkg::MODE_WORD;
                    held_byte  = txt_tok_pkg::CH_SLASH;
                    held_valid = 1'b1;
                    token_len  = LEN_W'(1);
                    word_byte(b);
                end
            end
            txt_tok_pkg::MODE_COMMENT: begin
                if (b == txt_tok_pkg::CH_NEWLINE || b == txt_tok_pkg::CH_EOD)
                    return_to_idle();
            end
            txt_tok_pkg::MODE_WORD:  word_byte(b);
            txt_tok_pkg::MODE_QUOTE: quoted_byte(b);
            default: begin
                return_to_idle();
                start_from_idle(b);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random draws
    // ------------------------------------------------------------------------
    // At least half of the beats go without a gap
    function automatic int draw_gap(input int max_gap);
        if (max_gap == 0 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, max_gap);
    endfunction

    function automatic logic [BYTE_W-1:0] word_char();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(33, 255));
        while (is_single(b) || b == quote_char || b == txt_tok_pkg::CH_SLASH);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] quoted_char();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(1, 255));
        while (b == quote_char);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] single_char();
        case ($urandom_range(0, 5))
            0:       return txt_tok_pkg::CH_LBRACE;
            1:       return txt_tok_pkg::CH_RBRACE;
            2:       return txt_tok_pkg::CH_LPAREN;
            3:       return txt_tok_pkg::CH_RPAREN;
            4:       return txt_tok_pkg::CH_APOSTROPHE;
            default: return txt_tok_pkg::CH_COMMA;
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input logic [PDATA_W-1:0] want,
                                          input logic [PDATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
    endfunction

    // ------------------------------------------------------------------------
    // Text sender: entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_gap(tx_gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
    endtask

    // Drop valid, drain every pending beat and let the block settle
    task automatic finish_phase();
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    task automatic check_quote_readback(input logic [BYTE_W-1:0] q);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_QUOTE_CHAR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {{(PDATA_W-BYTE_W){1'b0}}, q})
            note_mismatch("quote_char readback", {{(PDATA_W-BYTE_W){1'b0}}, q}, got);
    endtask

    task automatic set_quote_char(input logic [BYTE_W-1:0] q);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_QUOTE_CHAR;
        pwdata  <= {{(PDATA_W-BYTE_W){1'b0}}, q};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        quote_char = q;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        check_quote_readback(q);
    endtask

    // ------------------------------------------------------------------------
    // Token sink: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : token_sink
        int gap;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = draw_gap(rx_gap_max);
            if (rx_hold_req) begin
                gap = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Compare each beat that leaves with the oldest prediction
    always @(posedge aclk) begin : check_beats
        txt_tok_pkg::tok_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                note_mismatch("beat with none pending, tok_byte", '0,
                              PDATA_W'(m_tok_byte));
            end else begin
                want = pending_beats.pop_front();
                if (!want.tok_empty && m_tok_byte !== want.tok_byte)
                    note_mismatch("tok_byte", PDATA_W'(want.tok_byte),
                                  PDATA_W'(m_tok_byte));
                if (m_tok_last !== want.tok_last)
                    note_mismatch("tok_last", PDATA_W'(want.tok_last),
                                  PDATA_W'(m_tok_last));
                if (m_tok_empty !== want.tok_empty)
                    note_mismatch("tok_empty", PDATA_W'(want.tok_empty),
                                  PDATA_W'(m_tok_empty));
                if (m_tok_kind !== want.tok_kind)
                    note_mismatch("tok_kind", PDATA_W'(want.tok_kind),
                                  PDATA_W'(m_tok_kind));
            end
        end
    end

    // Abort when no beat or register access moves for too long
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_reset();
        check_quote_readback(txt_tok_pkg::QUOTE_CHAR_RST);
    endtask

    // Whitespace edges, words with slashes and quotes inside, punctuation,
    // quoted and empty quoted tokens, comments, lone slashes, end of data
    task automatic test_basic_tokens();
        send_byte(8'h01);
        send_text(" !//\"");
        send_byte(8'hFF);
        send_text("(){}',\"\"\" ");
        send_byte(8'h80);
        send_byte(txt_tok_pkg::CH_EOD);
        send_text("//z\n/q");
        send_byte(txt_tok_pkg::CH_EOD);
        send_byte(txt_tok_pkg::CH_SLASH);
        send_byte(txt_tok_pkg::CH_EOD);
        send_text("/ /{//");
        send_byte(txt_tok_pkg::CH_EOD);
        finish_phase();
    endtask

    task automatic test_quote_char_settings();
        // slash as quote: a lone slash opens a quoted token
        set_quote_char(txt_tok_pkg::CH_SLASH);
        send_text("/ab/ a/b /");
        send_byte(txt_tok_pkg::CH_EOD);
        send_text("//x\n");
        finish_phase();
        // quote equal to a punctuation byte: quoting wins
        set_quote_char(txt_tok_pkg::CH_LBRACE);
        send_text("{a{{{}");
        send_byte(txt_tok_pkg::CH_EOD);
        finish_phase();
        // quoting disabled by low settings
        set_quote_char(8'h00);
        send_text("\"x\" ");
        send_byte(txt_tok_pkg::CH_EOD);
        finish_phase();
        set_quote_char(txt_tok_pkg::CH_SPACE);
        send_text("a b\"");
        send_byte(txt_tok_pkg::CH_EOD);
        finish_phase();
        // high byte as quote, also as word text
        set_quote_char(8'hFF);
        send_byte(8'hFF);
        send_text("q r");
        send_byte(8'hFF);
        send_text("w");
        send_byte(8'hFF);
        send_byte(txt_tok_pkg::CH_EOD);
        finish_phase();
        set_quote_char(txt_tok_pkg::QUOTE_CHAR_RST);
    endtask

    task automatic test_token_length_limit();
        // full-length word closes itself, next byte starts afresh
        repeat (MAX_LEN) send_byte(word_char());
        send_text("k ");
        // full-length quoted token; the following quote opens a new one
        send_byte(quote_char);
        repeat (MAX_LEN) send_byte(quoted_char());
        send_text("\"x\"");
        // one byte short of the limit
        repeat (MAX_LEN - 1) send_byte(word_char());
        send_byte(txt_tok_pkg::CH_EOD);
        finish_phase();
    endtask

    // Hold the sink off while text keeps coming, so the input stalls
    task automatic test_output_backpressure();
        tx_gap_max  = 0;
        rx_hold_req = 1'b1;
        repeat (4) send_text("(ab,c){'x'} ");
        send_byte(txt_tok_pkg::CH_EOD);
        finish_phase();
        tx_gap_max = GAP_MAX;
    endtask

    task automatic send_random_token();
        int                pick;
        logic [BYTE_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            repeat ($urandom_range(1, 10)) send_byte(word_char());
            if ($urandom_range(0, 9) < 7)
                send_byte(txt_tok_pkg::CH_SPACE);
        end else if (pick < 45) begin
            send_byte(quote_char);
            repeat ($urandom_range(0, 8)) send_byte(quoted_char());
            send_byte(($urandom_range(0, 9) == 0) ? txt_tok_pkg::CH_EOD : quote_char);
        end else if (pick < 60) begin
            send_byte(single_char());
        end else if (pick < 72) begin
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(1, 32)));
        end else if (pick < 80) begin
            send_byte(txt_tok_pkg::CH_SLASH);
            send_byte(txt_tok_pkg::CH_SLASH);
            repeat ($urandom_range(0, 6)) begin
                do
                    b = BYTE_W'($urandom_range(1, 255));
                while (b == txt_tok_pkg::CH_NEWLINE);
                send_byte(b);
            end
            send_byte(($urandom_range(0, 19) == 0) ? txt_tok_pkg::CH_EOD
                                                   : txt_tok_pkg::CH_NEWLINE);
        end else if (pick < 86) begin
            send_byte(txt_tok_pkg::CH_SLASH);
            send_byte(BYTE_W'($urandom_range(0, 255)));
        end else if (pick < 90) begin
            send_byte(txt_tok_pkg::CH_EOD);
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Random text, including stray bytes, under several quote settings,
    // with and without idling on either side
    task automatic test_random_text();
        logic [BYTE_W-1:0] settings [5];
        int                target;
        settings = '{txt_tok_pkg::QUOTE_CHAR_RST, txt_tok_pkg::CH_SLASH,
                     txt_tok_pkg::CH_APOSTROPHE, 8'hFF, 8'h00};
        settings[4] = BYTE_W'($urandom_range(0, 255));
        for (int p = 0; p < 5; p++) begin
            set_quote_char(settings[p]);
            tx_gap_max = (p == 1 || p == 2) ? 0 : GAP_MAX;
            rx_gap_max = (p == 1 || p == 3) ? 0 : GAP_MAX;
            target = bytes_sent + RANDOM_ITEMS;
            while (bytes_sent < target)
                send_random_token();
            send_byte(txt_tok_pkg::CH_EOD);
            finish_phase();
        end
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        quote_char = txt_tok_pkg::QUOTE_CHAR_RST;
        return_to_idle();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_register_reset();
        test_basic_tokens();
        test_quote_char_settings();
        test_token_length_limit();
        test_output_backpressure();
        test_random_text();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
